>>> rtl/atesc_pkg.sv
// ----------------------------------------------------------------------------
// atesc_pkg
// Types and constants shared by the AT command and escape parser modules.
// ----------------------------------------------------------------------------
package atesc_pkg;

    typedef enum logic [1:0] {
        MODE_COMMAND  = 2'd0,
        MODE_ARGUMENT = 2'd1,
        MODE_STREAM   = 2'd2,
        MODE_ESCAPE   = 2'd3
    } t_mode;

    localparam logic [2:0] OP_BYTE    = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_STREAM  = 3'd2;
    localparam logic [2:0] OP_COMMAND = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] KIND_ARG  = 3'd0;
    localparam logic [2:0] KIND_CMD  = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_END  = 3'd3;
    localparam logic [2:0] KIND_DISC = 3'd4;

    localparam logic [7:0]  CHAR_PLUS   = 8'h2B;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [7:0]  CASE_OFFSET = 8'd32;
    localparam logic [23:0] ESCAPE_NAME = 24'h2B2B2B;
    localparam logic [1:0]  ESCAPE_LEN  = 2'd3;
    localparam logic [1:0]  PLUS_ARMED  = 2'd2;
    localparam logic [15:0] GUARD_RESET = 16'd1000;
    localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [23:0] name;
        logic [1:0]  len;
    } t_result;

    // All results caused by one input item, slot 0 first.
    typedef struct packed {
        logic [1:0]                    count;
        t_result [MAX_RESULTS-1:0]     slot;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_result make_result(input logic [2:0] kind, input logic [7:0] data,
                                            input logic [23:0] name, input logic [1:0] len);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.name = name;
        r.len  = len;
        return r;
    endfunction

endpackage

>>> rtl/atesc_front.sv
// ----------------------------------------------------------------------------
// atesc_front
// Accepts items, runs the parser state and classifies each item into a bundle
// of up to three results; a bundle with any results is pushed into the result queue.
// ----------------------------------------------------------------------------
module atesc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_op,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_guard_ticks,
    input  atesc_pkg::t_q_stat   i_q_stat,
    output logic                 o_in_ready,
    output logic                 o_push,
    output atesc_pkg::t_bundle   o_bundle
);
    import atesc_pkg::*;

    t_mode       r_mode, n_mode;
    logic [23:0] r_name, n_name;
    logic [1:0]  r_len, n_len;
    logic [1:0]  r_plus, n_plus;
    logic [15:0] r_timer, n_timer;
    logic        r_pending, n_pending;
    logic [15:0] r_guard;

    logic       acc;
    logic       is_eol, is_upper, is_lower, is_letter, is_plus, guard_met;
    logic [7:0] up_char;
    t_bundle    bundle;

    assign o_in_ready = i_rst_n && !i_q_stat.full;
    assign acc        = i_in_valid && o_in_ready;

    assign is_eol    = (i_rx_byte == CHAR_CR) || (i_rx_byte == CHAR_LF);
    assign is_upper  = (i_rx_byte >= 8'h41) && (i_rx_byte <= 8'h5A);
    assign is_lower  = (i_rx_byte >= 8'h61) && (i_rx_byte <= 8'h7A);
    assign is_letter = is_upper || is_lower;
    assign is_plus   = (i_rx_byte == CHAR_PLUS);
    assign up_char   = is_lower ? (i_rx_byte - CASE_OFFSET) : i_rx_byte;
    assign guard_met = (r_timer >= r_guard);

    // Mode transitions. A byte that is handed on to the next mode is folded in
    // here, so the mode lands where the last pass leaves it.
    always_comb begin
        n_mode = r_mode;
        if (acc) begin
            unique case (i_op)
                OP_BYTE: begin
                    unique case (r_mode)
                        MODE_COMMAND: begin
                            if (is_eol) begin
                                n_mode = MODE_COMMAND;
                            end else if (is_letter) begin
                                n_mode = (r_len >= 2'd2) ? MODE_ARGUMENT : MODE_COMMAND;
                            end else begin
                                n_mode = MODE_ARGUMENT;
                            end
                        end
                        MODE_ARGUMENT: begin
                            n_mode = is_eol ? MODE_COMMAND : MODE_ARGUMENT;
                        end
                        MODE_STREAM: begin
                            n_mode = is_plus ? MODE_ESCAPE : MODE_STREAM;
                        end
                        MODE_ESCAPE: begin
                            if (is_plus) begin
                                // A slow third plus keeps escape mode and restarts the escape.
                                n_mode = (r_plus == PLUS_ARMED && guard_met) ? MODE_COMMAND
                                                                              : MODE_ESCAPE;
                            end else begin
                                n_mode = MODE_STREAM;
                            end
                        end
                    endcase
                end
                OP_STREAM:  n_mode = MODE_STREAM;
                OP_COMMAND: n_mode = MODE_COMMAND;
                OP_CLEAR:   n_mode = MODE_COMMAND;
                default:    n_mode = r_mode;
            endcase
        end
    end

    // Results and the data part of the parser state.
    always_comb begin
        n_name    = r_name;
        n_len     = r_len;
        n_plus    = r_plus;
        n_timer   = r_timer;
        n_pending = r_pending;
        bundle    = '0;
        if (acc) begin
            unique case (i_op)
                OP_BYTE: begin
                    unique case (r_mode)
                        MODE_COMMAND: begin
                            if (is_eol) begin
                                if (r_len != 2'd0) begin
                                    bundle.count   = 2'd1;
                                    bundle.slot[0] = make_result(KIND_CMD, 8'd0, r_name, r_len);
                                    n_name         = '0;
                                    n_len          = '0;
                                end
                            end else if (is_letter || is_plus) begin
                                unique case (r_len)
                                    2'd0: begin
                                        n_name[23:16] = up_char;
                                        n_len         = 2'd1;
                                    end
                                    2'd1: begin
                                        n_name[15:8] = up_char;
                                        n_len        = 2'd2;
                                    end
                                    2'd2: begin
                                        n_name[7:0] = up_char;
                                        n_len       = 2'd3;
                                    end
                                    2'd3: ;
                                endcase
                            end else begin
                                bundle.count   = 2'd1;
                                bundle.slot[0] = make_result(KIND_ARG, i_rx_byte, 24'd0, 2'd0);
                            end
                        end
                        MODE_ARGUMENT: begin
                            bundle.count = 2'd1;
                            if (is_eol) begin
                                bundle.slot[0] = make_result(KIND_CMD, 8'd0, r_name, r_len);
                                n_name         = '0;
                                n_len          = '0;
                            end else begin
                                bundle.slot[0] = make_result(KIND_ARG, i_rx_byte, 24'd0, 2'd0);
                            end
                        end
                        MODE_STREAM: begin
                            if (is_plus) begin
                                n_plus  = 2'd1;
                                n_timer = '0;
                            end else begin
                                bundle.count   = 2'd1;
                                bundle.slot[0] = make_result(KIND_DATA, i_rx_byte, 24'd0, 2'd0);
                                n_pending      = 1'b1;
                            end
                        end
                        MODE_ESCAPE: begin
                            if (is_plus) begin
                                if (r_plus == PLUS_ARMED) begin
                                    if (guard_met) begin
                                        if (r_pending) begin
                                            bundle.count   = 2'd2;
                                            bundle.slot[0] = make_result(KIND_END, 8'd0,
                                                                         24'd0, 2'd0);
                                            bundle.slot[1] = make_result(KIND_CMD, 8'd0,
                                                                         ESCAPE_NAME, ESCAPE_LEN);
                                        end else begin
                                            bundle.count   = 2'd1;
                                            bundle.slot[0] = make_result(KIND_CMD, 8'd0,
                                                                         ESCAPE_NAME, ESCAPE_LEN);
                                        end
                                        n_pending = 1'b0;
                                        n_plus    = '0;
                                    end else begin
                                        // Release the first two pluses; the third starts over.
                                        bundle.count   = 2'd2;
                                        bundle.slot[0] = make_result(KIND_DATA, CHAR_PLUS,
                                                                     24'd0, 2'd0);
                                        bundle.slot[1] = make_result(KIND_DATA, CHAR_PLUS,
                                                                     24'd0, 2'd0);
                                        n_pending      = 1'b1;
                                        n_plus         = 2'd1;
                                        n_timer        = '0;
                                    end
                                end else begin
                                    n_plus = r_plus + 2'd1;
                                end
                            end else begin
                                // Held pluses go out first, then the byte itself as data.
                                for (int i = 0; i < MAX_RESULTS; i++) begin
                                    if (2'(i) < r_plus) begin
                                        bundle.slot[i] = make_result(KIND_DATA, CHAR_PLUS,
                                                                     24'd0, 2'd0);
                                    end else if (2'(i) == r_plus) begin
                                        bundle.slot[i] = make_result(KIND_DATA, i_rx_byte,
                                                                     24'd0, 2'd0);
                                    end
                                end
                                bundle.count = (r_plus == 2'd3) ? 2'd3 : (r_plus + 2'd1);
                                n_pending    = 1'b1;
                                n_plus       = '0;
                            end
                        end
                    endcase
                end
                OP_TICK: begin
                    if (r_timer != TIMER_MAX) begin
                        n_timer = r_timer + 16'd1;
                    end
                end
                OP_STREAM: begin
                    n_plus = '0;
                end
                OP_COMMAND: begin
                    if (r_mode == MODE_STREAM && r_pending) begin
                        bundle.count   = 2'd1;
                        bundle.slot[0] = make_result(KIND_END, 8'd0, 24'd0, 2'd0);
                        n_pending      = 1'b0;
                    end
                    n_plus = '0;
                end
                OP_CLEAR: begin
                    if (r_pending) begin
                        bundle.count   = 2'd1;
                        bundle.slot[0] = make_result(KIND_DISC, 8'd0, 24'd0, 2'd0);
                        n_pending      = 1'b0;
                    end
                    n_plus = '0;
                end
                default: ;
            endcase
        end
    end

    assign o_push   = acc && (bundle.count != 2'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_COMMAND;
            r_name    <= '0;
            r_len     <= '0;
            r_plus    <= '0;
            r_timer   <= '0;
            r_pending <= 1'b0;
            r_guard   <= GUARD_RESET;
        end else begin
            r_mode    <= n_mode;
            r_name    <= n_name;
            r_len     <= n_len;
            r_plus    <= n_plus;
            r_timer   <= n_timer;
            r_pending <= n_pending;
            if (i_cfg_valid) begin
                r_guard <= i_cfg_guard_ticks;
            end
        end
    end

endmodule

>>> rtl/atesc_queue.sv
// ----------------------------------------------------------------------------
// atesc_queue
// Short queue of result bundles between the parser front and the output back.
// ----------------------------------------------------------------------------
module atesc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  atesc_pkg::t_bundle   i_push_data,
    input  logic                 i_pop,
    output atesc_pkg::t_bundle   o_head,
    output atesc_pkg::t_q_stat   o_stat
);
    import atesc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : (r_wr + PW'(1));
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : (r_rd + PW'(1));
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

>>> rtl/atesc_back.sv
// ----------------------------------------------------------------------------
// atesc_back
// Takes bundles from the queue and sends their results one beat at a time,
// marking the final beat of each bundle.
// ----------------------------------------------------------------------------
module atesc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atesc_pkg::t_bundle   i_head,
    input  atesc_pkg::t_q_stat   i_q_stat,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_out_byte,
    output logic [23:0]          o_cmd_name,
    output logic [1:0]           o_cmd_name_len,
    output logic                 o_last
);
    import atesc_pkg::*;

    logic       r_busy;
    logic [1:0] r_idx;
    t_bundle    r_bundle;
    t_result    cur;
    logic       fire, at_last, done, load;

    assign cur     = r_bundle.slot[r_idx];
    assign fire    = r_busy && i_out_ready;
    assign at_last = (r_idx == (r_bundle.count - 2'd1));
    assign done    = fire && at_last;
    // The next bundle loads in the same cycle the last beat of this one leaves.
    assign load    = (!r_busy || done) && !i_q_stat.empty;
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bundle <= i_head;
        end
    end

    assign o_out_valid    = r_busy;
    assign o_kind         = cur.kind;
    assign o_out_byte     = cur.data;
    assign o_cmd_name     = cur.name;
    assign o_cmd_name_len = cur.len;
    assign o_last         = at_last;

endmodule

>>> rtl/at_command_escape_parser.sv
// ----------------------------------------------------------------------------
// at_command_escape_parser
// Accepts one item per cycle while the bundle queue has room; the front
// settles each item in the cycle it is accepted. Its results pass through
// the bundle queue and the back's bundle register before they are offered.
// One result beat leaves per cycle while the receiver is ready; an item has
// three results at most. Synchronous active-low reset returns to command mode,
// clears name, escape state and queue, and sets the guard to 1000 ticks.
// ----------------------------------------------------------------------------
module at_command_escape_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_guard_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [23:0] o_cmd_name,
    output logic [1:0]  o_cmd_name_len,
    output logic        o_last
);
    import atesc_pkg::*;

    t_q_stat q_stat;
    t_bundle push_bundle;
    t_bundle head_bundle;
    logic    push;
    logic    pop;

    assign o_cfg_ready = i_rst_n;

    atesc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_op              (i_op),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_guard_ticks (i_cfg_guard_ticks),
        .i_q_stat          (q_stat),
        .o_in_ready        (o_in_ready),
        .o_push            (push),
        .o_bundle          (push_bundle)
    );

    atesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_bundle),
        .i_pop       (pop),
        .o_head      (head_bundle),
        .o_stat      (q_stat)
    );

    atesc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_bundle),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_cmd_name     (o_cmd_name),
        .o_cmd_name_len (o_cmd_name_len),
        .o_last         (o_last)
    );

endmodule

>>> rtl/atesc_checker.sv
// ----------------------------------------------------------------------------
// atesc_checker
// Port-level checks for the AT command parser, bound to the top level.
// ----------------------------------------------------------------------------
module atesc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [23:0] o_cmd_name,
    input logic [1:0]  o_cmd_name_len,
    input logic        o_last
);
    import atesc_pkg::*;

    // No result beat may be offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat offered right after reset");

    // A stalled result beat keeps its kind, byte, name and last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_out_byte) && $stable(o_cmd_name) && $stable(o_last))
        else $error("stalled result beat changed");

    // Every command result closes the results of its input item.
    a_cmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_CMD |-> o_last)
        else $error("command result not marked last");

    // Only command results carry a name.
    a_name_only_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_CMD |-> o_cmd_name == 24'd0 && o_cmd_name_len == 2'd0)
        else $error("name field set on a non-command result");

endmodule

bind at_command_escape_parser atesc_checker u_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the AT command and escape parser. A predictor
// tracks mode, name, held pluses, escape timer and pending data for every
// accepted input beat and queues the result beats it causes. Each output beat
// is compared field by field with the oldest queued beat. Directed tests cover
// command parsing, stream data, escape timing, the guard extremes and back-pressure;
// random traffic then runs under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import atesc_pkg::*;

    localparam int CYCLE_LIMIT      = 50000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int PRESSURE_HOLD    = 300;
    localparam int RANDOM_PER_PHASE = 12;
    localparam int SENDER_IDLE_PCT  = 84;
    localparam int RECV_STALL_PCT   = 84;
    localparam int BOTH_IDLE_PCT    = 12;
    localparam int MAX_PASSES       = 4;
    localparam int SLOW_TICKS       = 3;

    localparam logic [2:0]  OP_LAST_CODE = 3'd7;
    localparam logic [1:0]  NAME_MAX     = 2'd3;
    localparam logic [15:0] GUARD_MIN    = 16'd0;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_expected_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_op;
    logic [7:0]  i_rx_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_guard_ticks;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [23:0] o_cmd_name;
    logic [1:0]  o_cmd_name_len;
    logic        o_last;

    // Predictor state.
    t_mode       parse_mode;
    logic [23:0] name_chars;
    logic [1:0]  name_len;
    logic [1:0]  plus_cnt;
    logic [15:0] esc_timer;
    logic        data_pending;
    logic [15:0] guard_ticks;

    t_result        item_beats[$];
    t_expected_beat expected_beats[$];

    t_idle idle_mode     = IDLE_NONE;
    int    hold_left     = 0;
    int    counted_items = 0;
    int    mismatch_count = 0;
    int    cycle_count   = 0;

    at_command_escape_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_guard_ticks (i_cfg_guard_ticks),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_out_byte        (o_out_byte),
        .o_cmd_name        (o_cmd_name),
        .o_cmd_name_len    (o_cmd_name_len),
        .o_last            (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic reset_parser_model();
        parse_mode   = MODE_COMMAND;
        name_chars   = '0;
        name_len     = '0;
        plus_cnt     = '0;
        esc_timer    = '0;
        data_pending = 1'b0;
        guard_ticks  = GUARD_RESET;
    endtask

    task automatic emit_result(input logic [2:0] kind, input logic [7:0] data,
                               input logic [23:0] name, input logic [1:0] len);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.name = name;
        r.len  = len;
        if (item_beats.size() < MAX_RESULTS) begin
            item_beats = {item_beats, r};
        end
    endtask

    task automatic emit_data(input logic [7:0] data);
        emit_result(KIND_DATA, data, '0, '0);
        data_pending = 1'b1;
    endtask

    task automatic append_name(input logic [7:0] ch);
        int shift;
        if (name_len < NAME_MAX) begin
            shift = 16 - 8 * int'(name_len);
            name_chars = name_chars | (24'(ch) << shift);
            name_len = name_len + 2'd1;
        end
    endtask

    // Handles one byte in the current mode; consumed is low when the byte has
    // to be handled again in the new mode.
    task automatic handle_byte(input logic [7:0] c, output bit consumed);
        logic eol;
        eol = (c == CHAR_CR) || (c == CHAR_LF);
        consumed = 1'b1;
        case (parse_mode)
            MODE_COMMAND: begin
                if (eol) begin
                    if (name_len != '0) begin
                        emit_result(KIND_CMD, '0, name_chars, name_len);
                        name_chars = '0;
                        name_len   = '0;
                    end
                end else if (c >= "a" && c <= "z") begin
                    append_name(c - CASE_OFFSET);
                end else if (c >= "A" && c <= "Z") begin
                    append_name(c);
                end else if (c == CHAR_PLUS) begin
                    append_name(c);
                    parse_mode = MODE_ARGUMENT;
                    return;
                end else begin
                    parse_mode = MODE_ARGUMENT;
                    consumed = 1'b0;
                    return;
                end
                if (name_len == NAME_MAX) begin
                    parse_mode = MODE_ARGUMENT;
                end
            end
            MODE_ARGUMENT: begin
                if (eol) begin
                    emit_result(KIND_CMD, '0, name_chars, name_len);
                    name_chars = '0;
                    name_len   = '0;
                    parse_mode = MODE_COMMAND;
                    consumed = 1'b0;
                end else begin
                    emit_result(KIND_ARG, c, '0, '0);
                end
            end
            MODE_STREAM: begin
                if (c == CHAR_PLUS) begin
                    plus_cnt   = 2'd1;
                    esc_timer  = '0;
                    parse_mode = MODE_ESCAPE;
                end else begin
                    emit_data(c);
                end
            end
            default: begin
                if (c == CHAR_PLUS) begin
                    plus_cnt = plus_cnt + 2'd1;
                    if (plus_cnt > PLUS_ARMED) begin
                        plus_cnt = '0;
                        if (esc_timer >= guard_ticks) begin
                            if (data_pending) begin
                                emit_result(KIND_END, '0, '0, '0);
                                data_pending = 1'b0;
                            end
                            emit_result(KIND_CMD, '0, ESCAPE_NAME, ESCAPE_LEN);
                            parse_mode = MODE_COMMAND;
                        end else begin
                            // Too slow: release the two earlier pluses; the
                            // third one opens a fresh escape in stream mode.
                            emit_data(CHAR_PLUS);
                            emit_data(CHAR_PLUS);
                            parse_mode = MODE_STREAM;
                            consumed = 1'b0;
                        end
                    end
                end else begin
                    for (int i = 0; i < int'(plus_cnt); i++) begin
                        emit_data(CHAR_PLUS);
                    end
                    plus_cnt   = '0;
                    parse_mode = MODE_STREAM;
                    consumed = 1'b0;
                end
            end
        endcase
    endtask

    task automatic predict_parser(input logic [2:0] op_code, input logic [7:0] c);
        bit             consumed;
        t_expected_beat b;
        item_beats.delete();
        case (op_code)
            OP_BYTE: begin
                for (int pass = 0; pass < MAX_PASSES; pass++) begin
                    handle_byte(c, consumed);
                    if (consumed) break;
                end
            end
            OP_TICK: begin
                if (esc_timer < TIMER_MAX) esc_timer = esc_timer + 16'd1;
            end
            OP_STREAM: begin
                plus_cnt   = '0;
                parse_mode = MODE_STREAM;
            end
            OP_COMMAND: begin
                if (parse_mode == MODE_STREAM && data_pending) begin
                    emit_result(KIND_END, '0, '0, '0);
                    data_pending = 1'b0;
                end
                plus_cnt   = '0;
                parse_mode = MODE_COMMAND;
            end
            OP_CLEAR: begin
                if (data_pending) begin
                    emit_result(KIND_DISC, '0, '0, '0);
                    data_pending = 1'b0;
                end
                plus_cnt   = '0;
                parse_mode = MODE_COMMAND;
            end
            default: ;
        endcase
        foreach (item_beats[i]) begin
            b.res  = item_beats[i];
            b.last = (i == item_beats.size() - 1);
            expected_beats = {expected_beats, b};
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return SENDER_IDLE_PCT;
            IDLE_BOTH:   return BOTH_IDLE_PCT;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return RECV_STALL_PCT;
            IDLE_BOTH:     return BOTH_IDLE_PCT;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Valid drops only in idle cycles, so back-to-back beats keep it high.
    task automatic send_item(input logic [2:0] op_code, input logic [7:0] rx);
        int gap_pct;
        gap_pct = sender_idle_pct();
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op       <= op_code;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (!o_in_ready);
        predict_parser(op_code, rx);
        if (op_code <= OP_CLEAR) counted_items++;
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0) @(posedge i_clk);
        // Items without results may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_guard(input logic [15:0] guard_val);
        @(negedge i_clk) i_in_valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_guard_ticks <= guard_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        guard_ticks = guard_val;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_expected_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d byte %0h name %0h",
                       o_kind, o_out_byte, o_cmd_name);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_kind !== want.res.kind) begin
                    $error("kind: expected %0d, actual %0d", want.res.kind, o_kind);
                    mismatch_count++;
                end
                if (o_out_byte !== want.res.data) begin
                    $error("out_byte: expected %0h, actual %0h", want.res.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_cmd_name !== want.res.name) begin
                    $error("cmd_name: expected %0h, actual %0h", want.res.name, o_cmd_name);
                    mismatch_count++;
                end
                if (o_cmd_name_len !== want.res.len) begin
                    $error("cmd_name_len: expected %0d, actual %0d",
                           want.res.len, o_cmd_name_len);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random sequence generators
    // ------------------------------------------------------------------------
    task automatic gen_command_line();
        logic [7:0] base;
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 6) == 0) begin
                send_item(OP_BYTE, CHAR_PLUS);
            end else begin
                base = ($urandom_range(0, 1) == 0) ? "a" : "A";
                send_item(OP_BYTE, base + 8'($urandom_range(0, 25)));
            end
        end
        repeat ($urandom_range(0, 3)) begin
            // Mostly printable arguments, now and then any byte at all.
            if ($urandom_range(0, 9) == 0) send_item(OP_BYTE, any_byte());
            else send_item(OP_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
        end
        send_item(OP_BYTE, ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
    endtask

    task automatic gen_stream_session();
        send_item(OP_STREAM, any_byte());
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, CHAR_PLUS);
            else send_item(OP_BYTE, any_byte());
        end
        if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 3; k++) begin
                repeat ($urandom_range(0, 3)) send_item(OP_TICK, any_byte());
                if (k == 2 && $urandom_range(0, 4) == 0) send_item(OP_BYTE, any_byte());
                send_item(OP_BYTE, CHAR_PLUS);
            end
        end
        case ($urandom_range(0, 3))
            0:       send_item(OP_COMMAND, any_byte());
            1:       send_item(OP_CLEAR, any_byte());
            default: ;
        endcase
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 3)) begin
            send_item(3'($urandom_range(0, OP_LAST_CODE)), any_byte());
        end
    endtask

    task automatic run_random_phase(input t_idle mode_sel, input logic [15:0] guard_val);
        int stop_at;
        write_guard(guard_val);
        idle_mode = mode_sel;
        stop_at = counted_items + RANDOM_PER_PHASE;
        while (counted_items < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gen_command_line();
                4, 5, 6, 7: gen_stream_session();
                default:    gen_noise();
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_command_parsing();
        idle_mode = IDLE_NONE;
        send_item(OP_BYTE, "a");
        send_item(OP_BYTE, "T");
        send_item(OP_BYTE, "d");
        send_item(OP_BYTE, "5");
        send_item(OP_BYTE, CHAR_CR);
        // End of line with an empty name in command mode emits nothing.
        send_item(OP_BYTE, CHAR_LF);
        // A plus is a name character and ends the name.
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_BYTE, CHAR_CR);
        // A non-letter moves to argument mode and is emitted there; the
        // command that follows has an empty name.
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, CHAR_LF);
    endtask

    task automatic test_stream_and_escape();
        idle_mode = IDLE_NONE;
        send_item(OP_STREAM, 8'hFF);
        // Three quick pluses at the reset guard are too slow for an escape.
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_BYTE, CHAR_PLUS);
        // A letter breaks the escape and releases both held pluses.
        send_item(OP_BYTE, "Z");
        send_item(OP_TICK, 8'hA5);
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_STREAM, 8'h00);
        send_item(OP_COMMAND, 8'h5A);
        send_item(OP_STREAM, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_LAST_CODE, 8'hFF);
    endtask

    task automatic test_guard_extremes();
        idle_mode = IDLE_NONE;
        // With no guard at all, three quick pluses close the data and escape.
        write_guard(GUARD_MIN);
        send_item(OP_STREAM, 8'h00);
        send_item(OP_BYTE, "d");
        repeat (3) send_item(OP_BYTE, CHAR_PLUS);
        // At the largest guard a few ticks are never enough, so the third plus
        // releases the first two and opens a new escape that a letter breaks.
        write_guard(TIMER_MAX);
        send_item(OP_STREAM, 8'h00);
        send_item(OP_BYTE, CHAR_PLUS);
        repeat (SLOW_TICKS) send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_BYTE, CHAR_PLUS);
        send_item(OP_BYTE, "x");
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_BYTE, "1");
        hold_left = PRESSURE_HOLD;
        repeat (12) send_item(OP_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
        send_item(OP_BYTE, CHAR_CR);
    endtask

    task automatic test_random_traffic();
        run_random_phase(IDLE_NONE, 16'($urandom_range(0, 3)));
        run_random_phase(IDLE_SENDER, 16'($urandom_range(0, 6)));
        run_random_phase(IDLE_RECEIVER, GUARD_MIN);
        run_random_phase(IDLE_BOTH, GUARD_RESET);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_op              = OP_BYTE;
        i_rx_byte         = 8'h00;
        i_cfg_valid       = 1'b0;
        i_cfg_guard_ticks = GUARD_RESET;
        reset_parser_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_command_parsing();
        test_stream_and_escape();
        test_guard_extremes();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk) i_in_valid <= 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> at_command_escape_parser.f
rtl/atesc_pkg.sv
rtl/atesc_front.sv
rtl/atesc_queue.sv
rtl/atesc_back.sv
rtl/at_command_escape_parser.sv
rtl/atesc_checker.sv
test/tb_top.sv
